### rtl/core/hrlt_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hrlt_pkg
// Shared types, codes and character constants for the HTTP request line
// tokenizer.
// ----------------------------------------------------------------------------
package hrlt_pkg;

   // Item limits; counters saturate here
   localparam logic [3:0] PARAM_LIMIT  = 4'd8;
   localparam logic [4:0] HEADER_LIMIT = 5'd16;

   // Characters the parser looks for
   localparam logic [7:0] CH_NUL   = 8'h00;
   localparam logic [7:0] CH_LF    = 8'h0A;
   localparam logic [7:0] CH_CR    = 8'h0D;
   localparam logic [7:0] CH_SPACE = 8'h20;
   localparam logic [7:0] CH_AMP   = 8'h26;
   localparam logic [7:0] CH_QMARK = 8'h3F;
   localparam logic [7:0] CH_E     = 8'h45;
   localparam logic [7:0] CH_G     = 8'h47;
   localparam logic [7:0] CH_O     = 8'h4F;
   localparam logic [7:0] CH_P     = 8'h50;
   localparam logic [7:0] CH_S     = 8'h53;
   localparam logic [7:0] CH_T     = 8'h54;
   localparam logic [7:0] CH_U     = 8'h55;

   // Parser phase
   typedef enum logic [2:0] {
      PH_METHOD,
      PH_PATH,
      PH_QMARK,
      PH_PARAM,
      PH_VERSION,
      PH_HEADER,
      PH_IGNORE
   } phase_type;

   // Region label of a byte
   typedef enum logic [2:0] {
      REG_METHOD,
      REG_PATH,
      REG_PARAM,
      REG_DELIM,
      REG_VERSION,
      REG_HEADER,
      REG_IGNORED,
      REG_TERM
   } region_type;

   // Method code
   typedef enum logic [2:0] {
      MC_PENDING,
      MC_GET,
      MC_POST,
      MC_PUT,
      MC_ERROR
   } method_type;

   // One result item
   typedef struct packed {
      logic        request_done;
      logic        overflow;
      logic [4:0]  header_total;
      logic [3:0]  param_total;
      method_type  method_code;
      logic        item_start;
      logic [4:0]  item_index;
      region_type  region;
   } result_type;

   // Length of the method word, including its closing space
   function automatic logic [2:0] method_len(method_type m);
      logic [2:0] len;
      case (m)
         MC_GET:  len = 3'd4;
         MC_POST: len = 3'd5;
         MC_PUT:  len = 3'd4;
         default: len = 3'd0;
      endcase
      return len;
   endfunction

   // Expected character of the method word at a position
   function automatic logic [7:0] method_char(method_type m, logic [2:0] pos);
      logic [7:0] ch;
      ch = CH_NUL;
      case (m)
         MC_GET: begin
            case (pos)
               3'd0:    ch = CH_G;
               3'd1:    ch = CH_E;
               3'd2:    ch = CH_T;
               3'd3:    ch = CH_SPACE;
               default: ch = CH_NUL;
            endcase
         end
         MC_POST: begin
            case (pos)
               3'd0:    ch = CH_P;
               3'd1:    ch = CH_O;
               3'd2:    ch = CH_S;
               3'd3:    ch = CH_T;
               3'd4:    ch = CH_SPACE;
               default: ch = CH_NUL;
            endcase
         end
         MC_PUT: begin
            case (pos)
               3'd0:    ch = CH_P;
               3'd1:    ch = CH_U;
               3'd2:    ch = CH_T;
               3'd3:    ch = CH_SPACE;
               default: ch = CH_NUL;
            endcase
         end
         default: ch = CH_NUL;
      endcase
      return ch;
   endfunction

endpackage

### rtl/core/http_request_line_tokenizer.sv
// Each accepted byte passes the input register, then the result register.
// Throughput: 1 byte per cycle while bytes arrive and rsp_ is not stalled.
// Input and result registers decouple the sides, so a byte is taken while a
// result still waits. Reset (synchronous, active high) empties both registers
// and returns the parser to the method phase with all counts cleared.
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// http_request_line_tokenizer
// Labels each HTTP request byte with region, item index and running totals.
// ----------------------------------------------------------------------------
module http_request_line_tokenizer (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // [7:0] data_byte
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [23:0] rsp_tdata,   // [2:0] region, [7:3] item_index,
                                    // [8] item_start, [11:9] method_code,
                                    // [15:12] param_total,
                                    // [20:16] header_total, [21] overflow
   output logic        rsp_tlast    // request_done
);

   logic                 hold_valid;
   logic [7:0]           hold_byte;
   logic                 room;
   logic                 step;
   hrlt_pkg::result_type result;

   // Parser advances when a byte is held and the result register has room
   assign step = hold_valid && room;

   hrlt_input_stage u_input (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .take       (step),
      .hold_valid (hold_valid),
      .hold_byte  (hold_byte)
   );

   hrlt_parse_core u_core (
      .clock     (clock),
      .reset     (reset),
      .step      (step),
      .data_byte (hold_byte),
      .result    (result)
   );

   hrlt_output_stage u_output (
      .clock      (clock),
      .reset      (reset),
      .load       (step),
      .result     (result),
      .room       (room),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast)
   );

   // Checks
   logic [2:0] rsp_region;
   logic [3:0] rsp_params;
   logic [4:0] rsp_headers;
   assign rsp_region  = rsp_tdata[2:0];
   assign rsp_params  = rsp_tdata[15:12];
   assign rsp_headers = rsp_tdata[20:16];

   a_last_is_term: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (rsp_tlast == (rsp_region == hrlt_pkg::REG_TERM)))
      else $error("tlast and terminator region disagree");

   a_param_sat: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (rsp_params <= hrlt_pkg::PARAM_LIMIT))
      else $error("parameter total above limit");

   a_header_sat: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (rsp_headers <= hrlt_pkg::HEADER_LIMIT))
      else $error("header total above limit");

   a_step_fills: assert property (@(posedge clock) disable iff (reset)
      step |=> rsp_tvalid)
      else $error("parsed item did not reach result register");

endmodule

### rtl/core/hrlt_input_stage.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hrlt_input_stage
// Input register for request bytes; holds one item until the parser takes it.
// ----------------------------------------------------------------------------
module hrlt_input_stage (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_tvalid,
   output logic       req_tready,
   input  logic [7:0] req_tdata,   // [7:0] data_byte
   input  logic       take,        // parser consumes the held item
   output logic       hold_valid,
   output logic [7:0] hold_byte
);

   logic       valid_ff, valid_in;
   logic [7:0] byte_ff,  byte_in;
   logic       accept;

   // Room when empty or when the held item leaves this cycle
   assign req_tready = !valid_ff || take;
   assign accept     = req_tvalid && req_tready;

   always_comb begin
      valid_in = valid_ff;
      byte_in  = byte_ff;
      if (accept) begin
         valid_in = 1'b1;
         byte_in  = req_tdata;
      end else if (take) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      byte_ff <= byte_in;
   end

   assign hold_valid = valid_ff;
   assign hold_byte  = byte_ff;

endmodule

### rtl/core/hrlt_parse_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hrlt_parse_core
// Parser state and per-byte labelling logic; state advances on each item.
// ----------------------------------------------------------------------------
module hrlt_parse_core (
   input  logic                clock,
   input  logic                reset,
   input  logic                step,
   input  logic [7:0]          data_byte,
   output hrlt_pkg::result_type result
);

   hrlt_pkg::phase_type  phase_ff,  phase_in;
   logic [2:0]           match_ff,  match_in;
   hrlt_pkg::method_type method_ff, method_in;
   logic [3:0]           param_ff,  param_in;
   logic [4:0]           header_ff, header_in;
   logic                 skip_ff,   skip_in;
   logic                 pending_ff, pending_in;
   logic                 ovf_ff,    ovf_in;

   logic is_brk;
   logic ends_path;

   assign is_brk    = (data_byte == hrlt_pkg::CH_CR) || (data_byte == hrlt_pkg::CH_LF);
   assign ends_path = is_brk || (data_byte == hrlt_pkg::CH_SPACE);

   // Next state and result for the byte at the input
   always_comb begin
      hrlt_pkg::method_type cand;
      logic                 ok;
      logic [2:0]           mlen;
      logic [3:0]           p1;
      logic                 handled;
      logic                 first;

      cand    = method_ff;
      ok      = 1'b0;
      mlen    = 3'd0;
      p1      = param_ff;
      handled = 1'b0;
      first   = 1'b0;

      phase_in   = phase_ff;
      match_in   = match_ff;
      method_in  = method_ff;
      param_in   = param_ff;
      header_in  = header_ff;
      skip_in    = skip_ff;
      pending_in = pending_ff;
      ovf_in     = ovf_ff;

      result              = '0;
      result.region       = hrlt_pkg::REG_IGNORED;
      result.method_code  = hrlt_pkg::MC_PENDING;

      if (data_byte == hrlt_pkg::CH_NUL) begin
         // Terminator: report totals, then back to the reset state
         result.region       = hrlt_pkg::REG_TERM;
         result.method_code  = (phase_ff == hrlt_pkg::PH_VERSION ||
                                phase_ff == hrlt_pkg::PH_HEADER) ?
                               method_ff : hrlt_pkg::MC_ERROR;
         result.param_total  = param_ff;
         result.header_total = header_ff;
         result.overflow     = ovf_ff;
         result.request_done = 1'b1;
         phase_in   = hrlt_pkg::PH_METHOD;
         match_in   = 3'd0;
         method_in  = hrlt_pkg::MC_PENDING;
         param_in   = 4'd0;
         header_in  = 5'd0;
         skip_in    = 1'b0;
         pending_in = 1'b0;
         ovf_in     = 1'b0;
      end else begin
         case (phase_ff)
            hrlt_pkg::PH_METHOD: begin
               if (match_ff == 3'd0) begin
                  if (data_byte == hrlt_pkg::CH_G) begin
                     cand = hrlt_pkg::MC_GET;
                     ok   = 1'b1;
                  end else if (data_byte == hrlt_pkg::CH_P) begin
                     cand = hrlt_pkg::MC_POST;
                     ok   = 1'b1;
                  end
                  if (ok) begin
                     method_in     = cand;
                     match_in      = 3'd1;
                     result.region = hrlt_pkg::REG_METHOD;
                  end
               end else begin
                  // POST and PUT share the first letter; 'U' switches over
                  if (match_ff == 3'd1 && cand == hrlt_pkg::MC_POST &&
                      data_byte == hrlt_pkg::CH_U) begin
                     cand = hrlt_pkg::MC_PUT;
                  end
                  method_in = cand;
                  mlen      = hrlt_pkg::method_len(cand);
                  if (mlen != 3'd0 && match_ff < mlen &&
                      data_byte == hrlt_pkg::method_char(cand, match_ff)) begin
                     ok = 1'b1;
                     if (match_ff + 3'd1 == mlen) begin
                        result.region = hrlt_pkg::REG_DELIM;
                        phase_in      = hrlt_pkg::PH_PATH;
                     end else begin
                        match_in      = match_ff + 3'd1;
                        result.region = hrlt_pkg::REG_METHOD;
                     end
                  end
               end
               if (!ok) begin
                  method_in     = hrlt_pkg::MC_ERROR;
                  phase_in      = hrlt_pkg::PH_IGNORE;
                  result.region = hrlt_pkg::REG_IGNORED;
               end
            end
            hrlt_pkg::PH_PATH: begin
               if (ends_path) begin
                  result.region = hrlt_pkg::REG_DELIM;
                  phase_in      = hrlt_pkg::PH_VERSION;
               end else if (data_byte == hrlt_pkg::CH_QMARK) begin
                  result.region = hrlt_pkg::REG_DELIM;
                  phase_in      = hrlt_pkg::PH_QMARK;
               end else begin
                  result.region = hrlt_pkg::REG_PATH;
               end
            end
            hrlt_pkg::PH_QMARK: begin
               if (ends_path) begin
                  result.region = hrlt_pkg::REG_DELIM;
                  phase_in      = hrlt_pkg::PH_VERSION;
               end else begin
                  // First parameter is counted here in either case
                  if (param_ff < hrlt_pkg::PARAM_LIMIT) p1 = param_ff + 4'd1;
                  else ovf_in = 1'b1;
                  phase_in = hrlt_pkg::PH_PARAM;
                  if (data_byte == hrlt_pkg::CH_AMP) begin
                     // Empty first parameter, then the one the '&' opens
                     if (p1 < hrlt_pkg::PARAM_LIMIT) param_in = p1 + 4'd1;
                     else begin
                        param_in = p1;
                        ovf_in   = 1'b1;
                     end
                     result.region = hrlt_pkg::REG_DELIM;
                     pending_in    = 1'b1;
                  end else begin
                     param_in          = p1;
                     result.region     = hrlt_pkg::REG_PARAM;
                     result.item_start = 1'b1;
                     result.item_index = {1'b0, p1} - 5'd1;
                     pending_in        = 1'b0;
                  end
               end
            end
            hrlt_pkg::PH_PARAM: begin
               if (ends_path) begin
                  result.region = hrlt_pkg::REG_DELIM;
                  phase_in      = hrlt_pkg::PH_VERSION;
                  pending_in    = 1'b0;
               end else if (data_byte == hrlt_pkg::CH_AMP) begin
                  if (param_ff < hrlt_pkg::PARAM_LIMIT) param_in = param_ff + 4'd1;
                  else ovf_in = 1'b1;
                  result.region = hrlt_pkg::REG_DELIM;
                  pending_in    = 1'b1;
               end else begin
                  result.region     = hrlt_pkg::REG_PARAM;
                  result.item_index = {1'b0, param_ff} - 5'd1;
                  result.item_start = pending_ff;
                  pending_in        = 1'b0;
               end
            end
            hrlt_pkg::PH_VERSION: begin
               if (is_brk) begin
                  result.region = hrlt_pkg::REG_DELIM;
                  phase_in      = hrlt_pkg::PH_HEADER;
                  skip_in       = 1'b1;
                  pending_in    = 1'b1;
               end else begin
                  result.region = hrlt_pkg::REG_VERSION;
               end
            end
            hrlt_pkg::PH_HEADER: begin
               // One extra CR or LF after a line break is dropped
               if (skip_ff) begin
                  skip_in = 1'b0;
                  if (is_brk) begin
                     result.region = hrlt_pkg::REG_DELIM;
                     handled       = 1'b1;
                  end
               end
               if (!handled) begin
                  if (pending_ff) begin
                     first      = (header_ff == 5'd0);
                     pending_in = 1'b0;
                     if (header_ff < hrlt_pkg::HEADER_LIMIT) header_in = header_ff + 5'd1;
                     else ovf_in = 1'b1;
                     if (first && is_brk) begin
                        result.region = hrlt_pkg::REG_DELIM;
                        skip_in       = 1'b1;
                        pending_in    = 1'b1;
                     end else begin
                        result.region     = hrlt_pkg::REG_HEADER;
                        result.item_start = 1'b1;
                        result.item_index = header_in - 5'd1;
                     end
                  end else if (is_brk) begin
                     result.region = hrlt_pkg::REG_DELIM;
                     skip_in       = 1'b1;
                     pending_in    = 1'b1;
                  end else begin
                     result.region     = hrlt_pkg::REG_HEADER;
                     result.item_index = header_ff - 5'd1;
                  end
               end
            end
            default: begin
               result.region = hrlt_pkg::REG_IGNORED;
            end
         endcase

         result.method_code  = (phase_in == hrlt_pkg::PH_METHOD) ?
                               hrlt_pkg::MC_PENDING : method_in;
         result.param_total  = param_in;
         result.header_total = header_in;
         result.overflow     = ovf_in;
      end
   end

   // State registers, advanced once per item
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff   <= hrlt_pkg::PH_METHOD;
         match_ff   <= 3'd0;
         method_ff  <= hrlt_pkg::MC_PENDING;
         param_ff   <= 4'd0;
         header_ff  <= 5'd0;
         skip_ff    <= 1'b0;
         pending_ff <= 1'b0;
         ovf_ff     <= 1'b0;
      end else if (step) begin
         phase_ff   <= phase_in;
         match_ff   <= match_in;
         method_ff  <= method_in;
         param_ff   <= param_in;
         header_ff  <= header_in;
         skip_ff    <= skip_in;
         pending_ff <= pending_in;
         ovf_ff     <= ovf_in;
      end
   end

endmodule

### rtl/core/hrlt_output_stage.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hrlt_output_stage
// Result register; holds one labelled item until the consumer takes it.
// ----------------------------------------------------------------------------
module hrlt_output_stage (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 load,
   input  hrlt_pkg::result_type result,
   output logic                 room,
   output logic                 rsp_tvalid,
   input  logic                 rsp_tready,
   output logic [23:0]          rsp_tdata,  // [2:0] region, [7:3] item_index,
                                            // [8] item_start, [11:9] method_code,
                                            // [15:12] param_total,
                                            // [20:16] header_total, [21] overflow
   output logic                 rsp_tlast   // request_done
);

   logic                 valid_ff, valid_in;
   hrlt_pkg::result_type data_ff,  data_in;

   // Free when empty or when the held item is taken this cycle
   assign room = !valid_ff || rsp_tready;

   always_comb begin
      valid_in = valid_ff;
      data_in  = data_ff;
      if (load) begin
         valid_in = 1'b1;
         data_in  = result;
      end else if (rsp_tready) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      data_ff <= data_in;
   end

   assign rsp_tvalid = valid_ff;
   assign rsp_tdata  = {2'b00, data_ff.overflow, data_ff.header_total,
                        data_ff.param_total, data_ff.method_code,
                        data_ff.item_start, data_ff.item_index, data_ff.region};
   assign rsp_tlast  = data_ff.request_done;

endmodule

### tb/http_request_line_tokenizer_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// http_request_line_tokenizer_tb
// Streams HTTP request bytes into the tokenizer. A cycle-level predictor
// labels every accepted byte, and each rsp_ item is checked field by field
// against the oldest label still waiting. A short directed part covers the
// method words, a bad method, empty and cut requests, '?' and '&' corner
// cases and line-break skipping. Random requests follow, mostly well formed
// with random content and sizes that reach the item limits, plus some noise.
// Both sides idle at random, and the receiver holds off once for a long
// stretch so that the block backs up into its input.
// ----------------------------------------------------------------------------
module http_request_line_tokenizer_tb;

   localparam int STALL_LIMIT  = 2000;   // cycles with no item moving
   localparam int RANDOM_BYTES = 600;
   localparam int LONG_HOLD    = 80;

   logic        clock      = 1'b0;
   logic        reset      = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [7:0]  req_tdata  = 8'h00;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [23:0] rsp_tdata;
   logic        rsp_tlast;

   http_request_line_tokenizer dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast)
   );

   always #6 clock = ~clock;

   // Bytes waiting to be sent, and labels waiting for their result item
   logic [7:0] byte_queue[$];
   logic [7:0] request_bytes[$];
   hrlt_pkg::result_type expected_labels[$];

   int bytes_accepted  = 0;
   int labels_checked  = 0;
   int requests_closed = 0;
   int method_errors   = 0;
   int overflow_closes = 0;
   int fail_count      = 0;
   int idle_cycles     = 0;
   int planned_bytes   = 0;

   // --------------------------------------------------------------------
   // Predictor: parser state and byte labelling
   // --------------------------------------------------------------------
   hrlt_pkg::phase_type  ph;
   logic [2:0]           word_pos;
   hrlt_pkg::method_type cand_method;
   logic [3:0]           n_params;
   logic [4:0]           n_headers;
   bit                   skip_break;
   bit                   item_open;
   bit                   ovf_seen;

   function automatic void clear_parser();
      ph          = hrlt_pkg::PH_METHOD;
      word_pos    = 3'd0;
      cand_method = hrlt_pkg::MC_PENDING;
      n_params    = 4'd0;
      n_headers   = 5'd0;
      skip_break  = 1'b0;
      item_open   = 1'b0;
      ovf_seen    = 1'b0;
   endfunction

   function automatic string method_text(hrlt_pkg::method_type m);
      case (m)
         hrlt_pkg::MC_GET:  return "GET ";
         hrlt_pkg::MC_POST: return "POST ";
         hrlt_pkg::MC_PUT:  return "PUT ";
         default: return "";
      endcase
   endfunction

   function automatic bit is_linebreak(logic [7:0] b);
      return b == hrlt_pkg::CH_CR || b == hrlt_pkg::CH_LF;
   endfunction

   function automatic bit closes_path(logic [7:0] b);
      return b == hrlt_pkg::CH_SPACE || is_linebreak(b);
   endfunction

   // Saturating item counts; one more past the limit flags overflow
   function automatic void count_param();
      if (n_params < hrlt_pkg::PARAM_LIMIT) n_params = n_params + 4'd1;
      else ovf_seen = 1'b1;
   endfunction

   function automatic void count_header();
      if (n_headers < hrlt_pkg::HEADER_LIMIT) n_headers = n_headers + 5'd1;
      else ovf_seen = 1'b1;
   endfunction

   function automatic hrlt_pkg::result_type label_byte(logic [7:0] b);
      hrlt_pkg::result_type r;
      string                word;
      logic [2:0]           mp;
      bit                   ok;
      bit                   first_hdr;
      r = '0;
      r.region = hrlt_pkg::REG_IGNORED;

      // Terminator reports final totals and restarts the parser
      if (b == hrlt_pkg::CH_NUL) begin
         r.region       = hrlt_pkg::REG_TERM;
         r.method_code  = (ph <= hrlt_pkg::PH_PARAM || ph > hrlt_pkg::PH_HEADER) ?
                          hrlt_pkg::MC_ERROR : cand_method;
         r.param_total  = n_params;
         r.header_total = n_headers;
         r.overflow     = ovf_seen;
         r.request_done = 1'b1;
         clear_parser();
         return r;
      end

      case (ph)
         hrlt_pkg::PH_METHOD: begin
            ok = 1'b0;
            if (word_pos == 3'd0) begin
               if (b == hrlt_pkg::CH_G) begin
                  cand_method = hrlt_pkg::MC_GET;
                  ok = 1'b1;
               end else if (b == hrlt_pkg::CH_P) begin
                  cand_method = hrlt_pkg::MC_POST;
                  ok = 1'b1;
               end
               if (ok) begin
                  word_pos = 3'd1;
                  r.region = hrlt_pkg::REG_METHOD;
               end
            end else begin
               mp = word_pos;
               // 'U' after 'P' switches the candidate to PUT
               if (mp == 3'd1 && cand_method == hrlt_pkg::MC_POST && b == hrlt_pkg::CH_U)
                  cand_method = hrlt_pkg::MC_PUT;
               word = method_text(cand_method);
               if (mp < word.len() && b == word[mp]) begin
                  ok = 1'b1;
                  if (mp + 1 == word.len()) begin
                     r.region = hrlt_pkg::REG_DELIM;
                     ph = hrlt_pkg::PH_PATH;
                  end else begin
                     word_pos = mp + 3'd1;
                     r.region = hrlt_pkg::REG_METHOD;
                  end
               end
            end
            if (!ok) begin
               cand_method = hrlt_pkg::MC_ERROR;
               ph = hrlt_pkg::PH_IGNORE;
               r.region = hrlt_pkg::REG_IGNORED;
            end
         end
         hrlt_pkg::PH_PATH: begin
            if (closes_path(b)) begin
               r.region = hrlt_pkg::REG_DELIM;
               ph = hrlt_pkg::PH_VERSION;
            end else if (b == hrlt_pkg::CH_QMARK) begin
               r.region = hrlt_pkg::REG_DELIM;
               ph = hrlt_pkg::PH_QMARK;
            end else r.region = hrlt_pkg::REG_PATH;
         end
         hrlt_pkg::PH_QMARK: begin
            if (closes_path(b)) begin
               r.region = hrlt_pkg::REG_DELIM;
               ph = hrlt_pkg::PH_VERSION;
            end else if (b == hrlt_pkg::CH_AMP) begin
               // empty first parameter plus the one the '&' opens
               count_param();
               count_param();
               r.region = hrlt_pkg::REG_DELIM;
               ph = hrlt_pkg::PH_PARAM;
               item_open = 1'b1;
            end else begin
               count_param();
               r.region = hrlt_pkg::REG_PARAM;
               r.item_start = 1'b1;
               r.item_index = {1'b0, n_params} - 5'd1;
               ph = hrlt_pkg::PH_PARAM;
               item_open = 1'b0;
            end
         end
         hrlt_pkg::PH_PARAM: begin
            if (closes_path(b)) begin
               r.region = hrlt_pkg::REG_DELIM;
               ph = hrlt_pkg::PH_VERSION;
               item_open = 1'b0;
            end else if (b == hrlt_pkg::CH_AMP) begin
               count_param();
               r.region = hrlt_pkg::REG_DELIM;
               item_open = 1'b1;
            end else begin
               r.region = hrlt_pkg::REG_PARAM;
               r.item_index = {1'b0, n_params} - 5'd1;
               r.item_start = item_open;
               item_open = 1'b0;
            end
         end
         hrlt_pkg::PH_VERSION: begin
            if (is_linebreak(b)) begin
               r.region = hrlt_pkg::REG_DELIM;
               ph = hrlt_pkg::PH_HEADER;
               skip_break = 1'b1;
               item_open = 1'b1;
            end else r.region = hrlt_pkg::REG_VERSION;
         end
         hrlt_pkg::PH_HEADER: begin
            ok = 1'b0;
            // one extra CR or LF after a line break is swallowed
            if (skip_break) begin
               skip_break = 1'b0;
               if (is_linebreak(b)) begin
                  r.region = hrlt_pkg::REG_DELIM;
                  ok = 1'b1;
               end
            end
            if (!ok) begin
               if (item_open) begin
                  first_hdr = (n_headers == 5'd0);
                  item_open = 1'b0;
                  count_header();
                  if (first_hdr && is_linebreak(b)) begin
                     r.region = hrlt_pkg::REG_DELIM;
                     skip_break = 1'b1;
                     item_open = 1'b1;
                  end else begin
                     r.region = hrlt_pkg::REG_HEADER;
                     r.item_start = 1'b1;
                     r.item_index = n_headers - 5'd1;
                  end
               end else if (is_linebreak(b)) begin
                  r.region = hrlt_pkg::REG_DELIM;
                  skip_break = 1'b1;
                  item_open = 1'b1;
               end else begin
                  r.region = hrlt_pkg::REG_HEADER;
                  r.item_index = n_headers - 5'd1;
               end
            end
         end
         default: r.region = hrlt_pkg::REG_IGNORED;
      endcase

      r.method_code  = (ph == hrlt_pkg::PH_METHOD) ? hrlt_pkg::MC_PENDING : cand_method;
      r.param_total  = n_params;
      r.header_total = n_headers;
      r.overflow     = ovf_seen;
      return r;
   endfunction

   // --------------------------------------------------------------------
   // Request builders
   // --------------------------------------------------------------------
   function automatic void add_text(string s);
      for (int i = 0; i < s.len(); i++) request_bytes.push_back(s[i]);
   endfunction

   // Random byte that avoids the given delimiters
   function automatic logic [7:0] plain_char(bit no_space, bit no_qmark, bit no_amp);
      logic [7:0] c;
      do c = 8'($urandom_range(1, 255));
      while (is_linebreak(c) || (no_space && c == hrlt_pkg::CH_SPACE) ||
             (no_qmark && c == hrlt_pkg::CH_QMARK) || (no_amp && c == hrlt_pkg::CH_AMP));
      return c;
   endfunction

   function automatic void add_linebreak();
      case ($urandom_range(0, 4))
         0: request_bytes.push_back(hrlt_pkg::CH_CR);
         1: request_bytes.push_back(hrlt_pkg::CH_LF);
         2: add_text("\r\n");
         3: add_text("\n\r");
         default: add_text("\r\r");
      endcase
   endfunction

   // Moves the staged request into the send queue, closed by a zero byte
   function automatic void commit_request();
      while (request_bytes.size() > 0) byte_queue.push_back(request_bytes.pop_front());
      byte_queue.push_back(hrlt_pkg::CH_NUL);
   endfunction

   function automatic void add_random_request();
      int                   kind;
      bit                   big;
      int                   n;
      int                   pos;
      hrlt_pkg::method_type m;
      kind = $urandom_range(0, 9);
      big  = ($urandom_range(0, 4) == 0);
      request_bytes.delete();
      if (kind == 0) begin
         // noise, sometimes behind a method prefix
         if ($urandom_range(0, 1)) add_text($urandom_range(0, 1) ? "PO" : "G");
         n = $urandom_range(1, 8);
         repeat (n) request_bytes.push_back(8'($urandom_range(1, 255)));
      end else begin
         m = hrlt_pkg::method_type'($urandom_range(hrlt_pkg::MC_GET,
                                                   hrlt_pkg::MC_PUT));
         add_text(method_text(m));
         n = $urandom_range(0, 4);
         repeat (n) request_bytes.push_back(plain_char(1'b1, 1'b1, 1'b0));
         if ($urandom_range(0, 2) != 0) begin
            request_bytes.push_back(hrlt_pkg::CH_QMARK);
            n = big ? $urandom_range(0, 11) : $urandom_range(0, 3);
            for (int i = 0; i < n; i++) begin
               if (i > 0) request_bytes.push_back(hrlt_pkg::CH_AMP);
               repeat ($urandom_range(0, 3))
                  request_bytes.push_back(plain_char(1'b1, 1'b0, 1'b1));
            end
         end
         case ($urandom_range(0, 3))
            0: request_bytes.push_back(hrlt_pkg::CH_CR);
            1: request_bytes.push_back(hrlt_pkg::CH_LF);
            default: request_bytes.push_back(hrlt_pkg::CH_SPACE);
         endcase
         repeat ($urandom_range(0, 4)) request_bytes.push_back(plain_char(1'b0, 1'b0, 1'b0));
         add_linebreak();
         n = big ? $urandom_range(14, 18) : $urandom_range(0, 3);
         repeat (n) begin
            repeat ($urandom_range(0, 4))
               request_bytes.push_back(plain_char(1'b0, 1'b0, 1'b0));
            add_linebreak();
         end
         // broken variants: one byte corrupted, or the request cut short
         if (kind == 1) begin
            pos = $urandom_range(0, request_bytes.size() - 1);
            request_bytes[pos] = 8'($urandom_range(1, 255));
         end else if (kind == 2) begin
            pos = $urandom_range(0, request_bytes.size() - 1);
            while (request_bytes.size() > pos) void'(request_bytes.pop_back());
         end
      end
      planned_bytes += request_bytes.size() + 1;
      commit_request();
   endfunction

   // --------------------------------------------------------------------
   // Driver: bursts of items with random gaps, predicts on acceptance
   // --------------------------------------------------------------------
   int burst_left = 1;
   int gap_left   = 0;

   always @(posedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
         gap_left   <= 0;
         burst_left <= 1;
      end else begin
         if (req_tvalid && req_tready) begin
            expected_labels.push_back(label_byte(req_tdata));
            bytes_accepted <= bytes_accepted + 1;
         end
         if (req_tvalid && !req_tready) begin
            // hold the item until it is taken
         end else if (gap_left > 0) begin
            gap_left   <= gap_left - 1;
            req_tvalid <= 1'b0;
         end else if (byte_queue.size() > 0) begin
            req_tvalid <= 1'b1;
            req_tdata  <= byte_queue.pop_front();
            if (burst_left <= 1) begin
               burst_left <= $urandom_range(1, 24);
               gap_left   <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
            end else burst_left <= burst_left - 1;
         end else req_tvalid <= 1'b0;
      end
   end

   // --------------------------------------------------------------------
   // Receiver: stall pattern that changes mode, plus one long hold-off
   // --------------------------------------------------------------------
   int ready_cycle     = 0;
   int stall_mode      = 0;
   int hold_left       = 0;
   bit long_hold_done  = 1'b0;

   always @(posedge clock) begin
      if (reset) begin
         rsp_tready  <= 1'b0;
         ready_cycle <= 0;
      end else begin
         ready_cycle <= ready_cycle + 1;
         if (ready_cycle % 50 == 0) stall_mode <= $urandom_range(0, 3);
         if (hold_left > 0) begin
            hold_left  <= hold_left - 1;
            rsp_tready <= 1'b0;
         end else if (!long_hold_done && bytes_accepted >= 200) begin
            hold_left      <= LONG_HOLD;
            long_hold_done <= 1'b1;
            rsp_tready     <= 1'b0;
         end else begin
            case (stall_mode)
               0: rsp_tready <= 1'b1;
               1: rsp_tready <= 1'($urandom_range(0, 1));
               2: rsp_tready <= (ready_cycle % 4 == 0);
               default: rsp_tready <= ready_cycle[3];
            endcase
         end
      end
   end

   // --------------------------------------------------------------------
   // Monitor: compare each result item with the oldest label
   // --------------------------------------------------------------------
   function automatic void note_failure(string msg);
      if (fail_count < 10) $display("ERROR at %0t: %s", $realtime, msg);
      fail_count++;
   endfunction

   function automatic string fields_text(hrlt_pkg::result_type r);
      return $sformatf("rgn %0d idx %0d st %0d mc %0d par %0d hdr %0d ovf %0d done %0d",
                       r.region, r.item_index, r.item_start, r.method_code,
                       r.param_total, r.header_total, r.overflow, r.request_done);
   endfunction

   always @(posedge clock) begin
      hrlt_pkg::result_type got;
      hrlt_pkg::result_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         got = hrlt_pkg::result_type'({rsp_tlast, rsp_tdata[21:0]});
         if (got.request_done) begin
            requests_closed <= requests_closed + 1;
            if (got.method_code == hrlt_pkg::MC_ERROR) method_errors <= method_errors + 1;
            if (got.overflow) overflow_closes <= overflow_closes + 1;
         end
         if (expected_labels.size() == 0) begin
            note_failure($sformatf("result item with none expected, tdata %h last %b",
                                   rsp_tdata, rsp_tlast));
         end else begin
            want = expected_labels.pop_front();
            labels_checked <= labels_checked + 1;
            if (got.region !== want.region || got.item_index !== want.item_index ||
                got.item_start !== want.item_start ||
                got.method_code !== want.method_code ||
                got.param_total !== want.param_total ||
                got.header_total !== want.header_total ||
                got.overflow !== want.overflow ||
                got.request_done !== want.request_done || rsp_tdata[23:22] !== 2'b00)
               note_failure($sformatf("item %0d: exp %s / got %s pad %b",
                                      labels_checked, fields_text(want),
                                      fields_text(got), rsp_tdata[23:22]));
         end
      end
   end

   // Watchdog: cycles in which no item moves on either side
   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready))
         idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
   end

   // --------------------------------------------------------------------
   // Stimulus and end of run
   // --------------------------------------------------------------------
   initial begin
      clear_parser();

      // empty request
      commit_request();
      // bad second method byte, all-ones byte
      request_bytes.push_back(hrlt_pkg::CH_G);
      request_bytes.push_back(8'hFF);
      commit_request();
      // '&' right after '?', then breaks: skipped one and an empty first header
      add_text("PUT ?&a\n\n\n\n");
      commit_request();
      // '?' closed at once by CR, short version, header without break skip
      add_text("POST ?\rV\rX");
      commit_request();
      // request cut inside the method word
      add_text("GE");
      commit_request();

      while (planned_bytes < RANDOM_BYTES) add_random_request();

      repeat (8) @(posedge clock);
      reset <= 1'b0;

      while (!((byte_queue.size() == 0 && !req_tvalid && expected_labels.size() == 0) ||
               idle_cycles >= STALL_LIMIT))
         @(posedge clock);

      if (idle_cycles >= STALL_LIMIT) begin
         $display("timeout: no item moved for %0d cycles, %0d results outstanding",
                  STALL_LIMIT, expected_labels.size());
         $display("FAILURE");
      end else begin
         repeat (10) @(posedge clock);
         if (expected_labels.size() != 0)
            note_failure($sformatf("%0d results never arrived", expected_labels.size()));
         $display("Covered %0d request bytes in %0d requests, %0d result items checked;",
                  bytes_accepted, requests_closed, labels_checked);
         $display("%0d requests ended with a method error, %0d with an item overflow.",
                  method_errors, overflow_closes);
         if (fail_count == 0) $display("SUCCESS");
         else $display("FAILURE");
      end
      $finish;
   end

endmodule
